// ===== hdl/mfbh_pkg.sv =====
`default_nettype none
package mfbh_pkg;

  localparam int StoreBytesDefault = 64;
  localparam int BackW = 6;

  localparam logic [63:0] K0 = 64'hB2D14DF0743669B1;
  localparam logic [63:0] K1 = 64'hA6553A9CA35693C5;
  localparam logic [63:0] K2 = 64'h6A2B6696D1B8D8D1;
  localparam logic [63:0] K3 = 64'hC35A93A3D287A5D1;
  localparam logic [63:0] K4 = 64'hB18D0F8759D13363;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [63:0] hash_wide;
    logic [31:0] hash_narrow;
  } hash_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISP, ST_LOAD, ST_DRAIN, ST_MUL, ST_MRES, ST_PUT
  } state_t;

  typedef enum logic [2:0] {
    JOB_WIDE, JOB_FIN, JOB_LONG, JOB_SH4, JOB_SH1, JOB_ZERO, JOB_MIX
  } job_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_LOAD, ACT_MUL, ACT_PUT, ACT_IDLE
  } act_t;

  function automatic logic [63:0] wide_key(input logic [1:0] k);
    case (k)
      2'd0:    wide_key = K1;
      2'd1:    wide_key = K2;
      default: wide_key = K3;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/multiply_fold_byte_hash64.sv =====
// Streaming 64-bit multiply-fold hash, one message byte per beat on msg; a beat with last
// set ends the message and yields one beat on hash (hash_wide and its 32-bit fold). Bytes
// go into a circular byte memory. Plain bytes do not stall the input. The byte that arrives
// with 48 bytes pending stalls the input while three lane mixes run over those 48, and the end
// of a message stalls it for a time set by its length, plus any wait on hash_ready. The
// stalls come from the memory's one byte-wide read port (one byte per cycle plus a
// dispatch and a drain state per word) and the single 32x32 multiplier, which builds each
// 64x64 product from four partial products. The seed on cfg is to be written by the user
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module multiply_fold_byte_hash64 #(
  parameter int STORE_BYTES = mfbh_pkg::StoreBytesDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           msg_valid,
  output logic                msg_ready,
  input  wire mfbh_pkg::msg_t msg,
  output logic                hash_valid,
  input  wire logic           hash_ready,
  output mfbh_pkg::hash_t     hash,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [63:0]    cfg_data
);

  localparam int PtrW = $clog2(STORE_BYTES);
  localparam logic [PtrW:0] Depth = (PtrW + 1)'(STORE_BYTES);

  mfbh_pkg::state_t state, state_next;
  mfbh_pkg::job_t   job;
  mfbh_pkg::act_t   act;

  logic [63:0] hash_seed;
  logic [7:0]  mem [STORE_BYTES];
  logic [7:0]  rdata;
  logic [PtrW-1:0] wr_ptr, ld_addr, ld_start;
  logic [3:0]  ld_cnt, ld_len;
  logic        rd_v;
  logic [63:0] byte_count;
  logic [5:0]  pend, left;
  logic        wide_done, fin_pend;
  logic [63:0] lane_main, lane_second, lane_third, lane_sel;
  logic [1:0]  k;
  logic [2:0]  step, mcnt;
  logic [63:0] acc, opa, opb, s, mres, pp;
  logic [127:0] prod;
  logic [mfbh_pkg::BackW-1:0] back, n_rem;
  logic        msg_acc;

  function automatic logic [PtrW-1:0] ptr_sub(input logic [PtrW-1:0] p,
                                              input logic [mfbh_pkg::BackW-1:0] d);
    logic [PtrW:0] pw, dw;
    pw = {1'b0, p};
    dw = (PtrW + 1)'(d);
    if (dw > pw) ptr_sub = PtrW'(pw + Depth - dw);
    else ptr_sub = PtrW'(pw - dw);
  endfunction

  assign cfg_ready = 1'b1;
  assign msg_acc   = msg_valid && msg_ready;
  assign n_rem     = {2'b00, pend[4:3], 2'b00};

  always_comb begin
    case (k)
      2'd0:    lane_sel = lane_main;
      2'd1:    lane_sel = lane_second;
      default: lane_sel = lane_third;
    endcase
  end

  // dispatcher: what the current step launches
  always_comb begin
    act = mfbh_pkg::ACT_NONE;
    back = '0;
    ld_len = 4'd8;
    case (job)
      mfbh_pkg::JOB_WIDE: begin
        case (step)
          3'd0: begin
            act = mfbh_pkg::ACT_LOAD;
            back = 6'd49 - {k, 4'b0000};
          end
          3'd1: begin
            act = mfbh_pkg::ACT_LOAD;
            back = 6'd41 - {k, 4'b0000};
          end
          3'd3: act = mfbh_pkg::ACT_MUL;
          3'd4: act = (k == 2'd2 && !fin_pend) ? mfbh_pkg::ACT_IDLE : mfbh_pkg::ACT_NONE;
          default: act = mfbh_pkg::ACT_NONE;
        endcase
      end
      mfbh_pkg::JOB_LONG: begin
        case (step)
          3'd0: begin
            act = mfbh_pkg::ACT_LOAD;
            back = (left > 6'd16) ? left : 6'd16;
          end
          3'd1: begin
            act = mfbh_pkg::ACT_LOAD;
            back = left - 6'd8;
          end
          3'd3: begin
            act = mfbh_pkg::ACT_LOAD;
            back = 6'd8;
          end
          3'd6: act = mfbh_pkg::ACT_MUL;
          default: act = mfbh_pkg::ACT_NONE;
        endcase
      end
      mfbh_pkg::JOB_SH4: begin
        ld_len = 4'd4;
        case (step)
          3'd0: begin
            act = mfbh_pkg::ACT_LOAD;
            back = pend;
          end
          3'd1: begin
            act = mfbh_pkg::ACT_LOAD;
            back = pend - n_rem;
          end
          3'd2: begin
            act = mfbh_pkg::ACT_LOAD;
            back = 6'd4;
          end
          3'd3: begin
            act = mfbh_pkg::ACT_LOAD;
            back = 6'd4 + n_rem;
          end
          default: act = mfbh_pkg::ACT_NONE;
        endcase
      end
      mfbh_pkg::JOB_SH1: begin
        ld_len = 4'd1;
        case (step)
          3'd0: begin
            act = mfbh_pkg::ACT_LOAD;
            back = pend;
          end
          3'd1: begin
            act = mfbh_pkg::ACT_LOAD;
            back = pend - {1'b0, pend[5:1]};
          end
          3'd2: begin
            act = mfbh_pkg::ACT_LOAD;
            back = 6'd1;
          end
          default: act = mfbh_pkg::ACT_NONE;
        endcase
      end
      mfbh_pkg::JOB_MIX: begin
        case (step)
          3'd1, 3'd3: act = mfbh_pkg::ACT_MUL;
          3'd4:       act = mfbh_pkg::ACT_PUT;
          default:    act = mfbh_pkg::ACT_NONE;
        endcase
      end
      default: act = mfbh_pkg::ACT_NONE;
    endcase
  end

  assign ld_start = ptr_sub(wr_ptr, back - mfbh_pkg::BackW'(ld_len) + 6'd1);

  always_comb begin
    state_next = state;
    case (state)
      mfbh_pkg::ST_IDLE: begin
        if (msg_acc && ((msg.has_byte && pend == 6'd48) || msg.last)) begin
          state_next = mfbh_pkg::ST_DISP;
        end
      end
      mfbh_pkg::ST_DISP: begin
        case (act)
          mfbh_pkg::ACT_LOAD: state_next = mfbh_pkg::ST_LOAD;
          mfbh_pkg::ACT_MUL:  state_next = mfbh_pkg::ST_MUL;
          mfbh_pkg::ACT_PUT:  state_next = mfbh_pkg::ST_PUT;
          mfbh_pkg::ACT_IDLE: state_next = mfbh_pkg::ST_IDLE;
          default:            state_next = mfbh_pkg::ST_DISP;
        endcase
      end
      mfbh_pkg::ST_LOAD:  if (ld_cnt == 4'd1) state_next = mfbh_pkg::ST_DRAIN;
      mfbh_pkg::ST_DRAIN: state_next = mfbh_pkg::ST_DISP;
      mfbh_pkg::ST_MUL:   if (mcnt == 3'd4) state_next = mfbh_pkg::ST_MRES;
      mfbh_pkg::ST_MRES:  state_next = mfbh_pkg::ST_DISP;
      mfbh_pkg::ST_PUT:   if (!hash_valid || hash_ready) state_next = mfbh_pkg::ST_IDLE;
      default:            state_next = mfbh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    msg_ready = (state == mfbh_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (msg_acc && msg.has_byte) mem[wr_ptr] <= msg.data_byte;
    rdata <= mem[ld_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mfbh_pkg::ST_IDLE;
      hash_seed  <= '0;
      wr_ptr     <= '0;
      byte_count <= '0;
      pend       <= '0;
      wide_done  <= 1'b0;
      hash_valid <= 1'b0;
      rd_v       <= 1'b0;
      job        <= mfbh_pkg::JOB_FIN;
      step       <= '0;
    end else begin
      state <= state_next;
      rd_v  <= (state == mfbh_pkg::ST_LOAD);
      if (cfg_valid) hash_seed <= cfg_data;
      if (hash_valid && hash_ready && state != mfbh_pkg::ST_PUT) hash_valid <= 1'b0;
      if (rd_v) acc <= {acc[55:0], rdata};
      case (state)
        mfbh_pkg::ST_IDLE: begin
          if (msg_acc) begin
            fin_pend <= msg.last;
            step     <= '0;
            if (msg.has_byte) begin
              if (pend == 6'd0 && !wide_done) begin
                lane_main   <= hash_seed ^ mfbh_pkg::K0;
                lane_second <= hash_seed ^ mfbh_pkg::K0;
                lane_third  <= hash_seed ^ mfbh_pkg::K0;
              end
              wr_ptr     <= (wr_ptr == PtrW'(STORE_BYTES - 1)) ? '0 : wr_ptr + 1'b1;
              byte_count <= byte_count + 64'd1;
              pend       <= pend + 6'd1;
            end
            if (msg.has_byte && pend == 6'd48) begin
              job <= mfbh_pkg::JOB_WIDE;
              k   <= '0;
            end else begin
              job <= mfbh_pkg::JOB_FIN;
            end
          end
        end
        mfbh_pkg::ST_DISP: begin
          if (act == mfbh_pkg::ACT_LOAD) begin
            ld_addr <= ld_start;
            ld_cnt  <= ld_len;
          end
          if (act == mfbh_pkg::ACT_MUL) mcnt <= '0;
          case (job)
            mfbh_pkg::JOB_WIDE: begin
              case (step)
                3'd1: opa <= acc ^ mfbh_pkg::wide_key(k);
                3'd2: opb <= acc ^ lane_sel;
                3'd4: begin
                  case (k)
                    2'd0:    lane_main <= mres;
                    2'd1:    lane_second <= mres;
                    default: lane_third <= mres;
                  endcase
                  if (k == 2'd2) begin
                    pend      <= 6'd1;
                    wide_done <= 1'b1;
                    job       <= mfbh_pkg::JOB_FIN;
                  end
                  k <= k + 2'd1;
                end
                default: ;
              endcase
              step <= (step == 3'd4) ? 3'd0 : step + 3'd1;
            end
            mfbh_pkg::JOB_FIN: begin
              left <= pend;
              step <= '0;
              if (!wide_done && pend <= 6'd16) begin
                if (pend == 6'd0) begin
                  s   <= hash_seed ^ mfbh_pkg::K0;
                  job <= mfbh_pkg::JOB_ZERO;
                end else begin
                  s   <= lane_main;
                  job <= (pend >= 6'd4) ? mfbh_pkg::JOB_SH4 : mfbh_pkg::JOB_SH1;
                end
              end else begin
                s   <= wide_done ? (lane_main ^ lane_second ^ lane_third) : lane_main;
                job <= mfbh_pkg::JOB_LONG;
              end
            end
            mfbh_pkg::JOB_LONG: begin
              case (step)
                3'd0: step <= (left > 6'd16) ? 3'd1 : 3'd3;
                3'd1: begin
                  opa  <= acc ^ mfbh_pkg::K1;
                  step <= 3'd2;
                end
                3'd2: begin
                  opb  <= acc ^ s;
                  step <= 3'd6;
                end
                3'd6: step <= 3'd5;
                3'd5: begin
                  s    <= mres;
                  left <= left - 6'd16;
                  step <= 3'd0;
                end
                3'd3: begin
                  opa  <= acc;
                  step <= 3'd4;
                end
                default: begin
                  opb  <= acc;
                  job  <= mfbh_pkg::JOB_MIX;
                  step <= 3'd0;
                end
              endcase
            end
            mfbh_pkg::JOB_SH4: begin
              if (step == 3'd2) opa <= acc;
              if (step == 3'd4) begin
                opb  <= acc;
                job  <= mfbh_pkg::JOB_MIX;
                step <= 3'd0;
              end else begin
                step <= step + 3'd1;
              end
            end
            mfbh_pkg::JOB_SH1: begin
              if (step == 3'd0) acc <= '0;
              if (step == 3'd3) begin
                opa  <= acc;
                opb  <= '0;
                job  <= mfbh_pkg::JOB_MIX;
                step <= 3'd0;
              end else begin
                step <= step + 3'd1;
              end
            end
            mfbh_pkg::JOB_ZERO: begin
              opa  <= '0;
              opb  <= '0;
              job  <= mfbh_pkg::JOB_MIX;
              step <= 3'd0;
            end
            default: begin
              case (step)
                3'd0: begin
                  opa <= opa ^ mfbh_pkg::K1;
                  opb <= opb ^ s;
                end
                3'd2: begin
                  opa <= mfbh_pkg::K4 ^ byte_count;
                  opb <= mres;
                end
                default: ;
              endcase
              if (step != 3'd4) step <= step + 3'd1;
            end
          endcase
        end
        mfbh_pkg::ST_LOAD: begin
          ld_addr <= (ld_addr == '0) ? PtrW'(STORE_BYTES - 1) : ld_addr - 1'b1;
          ld_cnt  <= ld_cnt - 4'd1;
        end
        mfbh_pkg::ST_MUL: begin
          mcnt <= mcnt + 3'd1;
          case (mcnt)
            3'd0: begin
              pp   <= opa[31:0] * opb[31:0];
              prod <= '0;
            end
            3'd1: begin
              pp   <= opa[31:0] * opb[63:32];
              prod <= prod + {64'd0, pp};
            end
            3'd2: begin
              pp   <= opa[63:32] * opb[31:0];
              prod <= prod + {32'd0, pp, 32'd0};
            end
            3'd3: begin
              pp   <= opa[63:32] * opb[63:32];
              prod <= prod + {32'd0, pp, 32'd0};
            end
            default: prod <= prod + {pp, 64'd0};
          endcase
        end
        mfbh_pkg::ST_MRES: begin
          mres <= (opa ^ prod[63:0]) ^ (opb ^ prod[127:64]);
        end
        mfbh_pkg::ST_PUT: begin
          if (!hash_valid || hash_ready) begin
            hash_valid       <= 1'b1;
            hash.hash_wide   <= mres;
            hash.hash_narrow <= mres[63:32] ^ mres[31:0];
            byte_count       <= '0;
            pend             <= '0;
            wide_done        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mfbh_chk.sv =====
`default_nettype none
module mfbh_chk (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            msg_valid,
  input wire logic            msg_ready,
  input wire mfbh_pkg::msg_t  msg,
  input wire logic            hash_valid,
  input wire logic            hash_ready,
  input wire mfbh_pkg::hash_t hash,
  input wire logic            cfg_valid,
  input wire logic            cfg_ready,
  input wire logic [63:0]     cfg_data
);

  a_fold: assert property (@(posedge clk) disable iff (rst)
    hash_valid |-> hash.hash_narrow == (hash.hash_wide[63:32] ^ hash.hash_wide[31:0]))
    else $error("narrow hash is not the fold of the wide hash");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    hash_valid && !hash_ready |=> hash_valid && $stable(hash))
    else $error("stalled hash beat changed");

  a_rst: assert property (@(posedge clk) rst |=> !hash_valid)
    else $error("hash beat after reset");

  a_idle_beat: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_ready && !msg.has_byte && !msg.last |=> msg_ready)
    else $error("empty beat stalled the input");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind multiply_fold_byte_hash64 mfbh_chk u_mfbh_chk (.*);
`default_nettype wire

// ===== bench/multiply_fold_byte_hash64_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module multiply_fold_byte_hash64_test;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_ready;
  mfbh_pkg::msg_t msg = '0;
  logic hash_valid;
  logic hash_ready = 1'b0;
  mfbh_pkg::hash_t hash;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [63:0] cfg_data = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multiply_fold_byte_hash64 u_dut (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_ready(msg_ready), .msg(msg),
    .hash_valid(hash_valid), .hash_ready(hash_ready), .hash(hash),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0] seed_reg;
  logic [7:0]  hist [64];
  int unsigned wptr, pend;
  logic [63:0] nbytes, lane_a, lane_b, lane_c;
  logic        block_mixed;

  mfbh_pkg::hash_t expected_hashes[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;

  int          edge_lens[7] = '{4, 8, 16, 17, 48, 49, 97};
  logic [63:0] edge_seeds[3] = '{64'hFFFFFFFFFFFFFFFF, 64'h0, 64'h123456789ABCDEF0};

  function automatic logic [63:0] fold_mul(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return (x ^ p[63:0]) ^ (y ^ p[127:64]);
  endfunction

  function automatic logic [63:0] back_byte(input int unsigned back);
    return {56'd0, hist[(wptr + 64 - (back % 64)) % 64]};
  endfunction

  function automatic logic [63:0] back_word(input int unsigned back, input int n);
    logic [63:0] v;
    v = 0;
    for (int i = n - 1; i >= 0; i--) v = (v << 8) | back_byte(back - i);
    return v;
  endfunction

  function automatic void restart_msg();
    nbytes = 0;
    pend = 0;
    block_mixed = 1'b0;
    lane_a = seed_reg ^ mfbh_pkg::K0;
    lane_b = lane_a;
    lane_c = lane_a;
  endfunction

  function automatic logic [63:0] final_hash();
    logic [63:0] a, b, s;
    int unsigned n, r, left;
    if (!block_mixed && pend <= 16) begin
      n = pend;
      s = (n == 0) ? (seed_reg ^ mfbh_pkg::K0) : lane_a;
      if (n >= 4) begin
        r = (n >> 3) << 2;
        a = (back_word(n, 4) << 32) | back_word(n - r, 4);
        b = (back_word(4, 4) << 32) | back_word(4 + r, 4);
      end else if (n > 0) begin
        a = (back_byte(n) << 16) | (back_byte(n - (n >> 1)) << 8) | back_byte(1);
        b = 0;
      end else begin
        a = 0;
        b = 0;
      end
    end else begin
      left = pend;
      s = lane_a;
      if (block_mixed) s ^= lane_b ^ lane_c;
      while (left > 16) begin
        s = fold_mul(back_word(left, 8) ^ mfbh_pkg::K1, back_word(left - 8, 8) ^ s);
        left -= 16;
      end
      a = back_word(16, 8);
      b = back_word(8, 8);
    end
    return fold_mul(mfbh_pkg::K4 ^ nbytes, fold_mul(a ^ mfbh_pkg::K1, b ^ s));
  endfunction

  function automatic void predict_beat(input mfbh_pkg::msg_t m);
    logic [63:0] h;
    if (m.has_byte) begin
      if (pend == 0 && !block_mixed) restart_msg();
      hist[wptr] = m.data_byte;
      wptr = (wptr + 1) % 64;
      nbytes++;
      pend++;
      if (pend == 49) begin
        lane_a = fold_mul(back_word(49, 8) ^ mfbh_pkg::K1, back_word(41, 8) ^ lane_a);
        lane_b = fold_mul(back_word(33, 8) ^ mfbh_pkg::K2, back_word(25, 8) ^ lane_b);
        lane_c = fold_mul(back_word(17, 8) ^ mfbh_pkg::K3, back_word(9, 8) ^ lane_c);
        pend = 1;
        block_mixed = 1'b1;
      end
    end
    if (m.last) begin
      h = final_hash();
      expected_hashes.push_back('{hash_wide: h, hash_narrow: h[63:32] ^ h[31:0]});
      restart_msg();
    end
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multiply_fold_byte_hash64 test failed");
      $finish;
    end
  end

  // result side
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    mfbh_pkg::hash_t want;
    if (!rst && hash_valid && hash_ready) begin
      if (expected_hashes.size() == 0) begin
        report("unexpected beat", hash.hash_wide, 64'd0);
      end else begin
        want = expected_hashes.pop_front();
        if (hash.hash_wide !== want.hash_wide)
          report("hash_wide", hash.hash_wide, want.hash_wide);
        if (hash.hash_narrow !== want.hash_narrow)
          report("hash_narrow", {32'd0, hash.hash_narrow}, {32'd0, want.hash_narrow});
      end
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 4) == 0) stall_left = 0;
    end
    if (hold_off) begin
      hash_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      hash_ready <= 1'b0;
    end else begin
      hash_ready <= 1'b1;
    end
  end

  bit burst_mode = 1'b0;

  task automatic send_beat(input mfbh_pkg::msg_t m);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (!burst_mode && $urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    predict_beat(m);
  endtask

  task automatic wait_drained();
    msg_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seed_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(input int len, input bit empty_tail);
    mfbh_pkg::msg_t m;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        m = '{data_byte: 8'($urandom), has_byte: 1'b0, last: 1'b0};
        send_beat(m);
      end
      m = '{data_byte: 8'($urandom), has_byte: 1'b1,
            last: (i == len - 1) && !empty_tail};
      send_beat(m);
    end
    if (empty_tail || len == 0) begin
      m = '{data_byte: 8'($urandom), has_byte: 1'b0, last: 1'b1};
      send_beat(m);
    end
  endtask

  typedef struct {
    mfbh_pkg::msg_t m;
    bit             check_now;
    logic [63:0]    want;
  } row_t;

  row_t rows[] = '{
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, 64'd0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, 64'd0},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b0, 64'd0},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, 64'd0},
    '{'{8'hA5, 1'b1, 1'b0}, 1'b0, 64'd0},
    '{'{8'h5A, 1'b1, 1'b0}, 1'b0, 64'd0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, 64'd0},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, 64'd0},
    '{'{8'h80, 1'b1, 1'b0}, 1'b0, 64'd0},
    '{'{8'h7F, 1'b1, 1'b0}, 1'b0, 64'd0},
    '{'{8'hFE, 1'b1, 1'b1}, 1'b0, 64'd0}
  };

  initial begin
    int len;
    seed_reg = 0;
    wptr = 0;
    for (int i = 0; i < 64; i++) hist[i] = 0;
    restart_msg();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_beat(rows[i].m);
    // message lengths around the load boundaries
    foreach (edge_lens[j]) send_message(edge_lens[j], 1'b0);
    wait_drained();

    foreach (edge_seeds[s]) begin
      write_seed(edge_seeds[s]);
      send_message(0, 1'b1);
      send_message(3, 1'b0);
      send_message(60, 1'b1);
      wait_drained();
    end

    for (int ph = 0; ph < 4; ph++) begin
      write_seed({$urandom, $urandom});
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 3))
          0: len = $urandom_range(0, 16);
          1: len = $urandom_range(17, 48);
          2: len = $urandom_range(49, 120);
          default: len = $urandom_range(0, 8);
        endcase
        send_message(len, $urandom_range(0, 3) == 0);
      end
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (2000) @(posedge clk);
            hold_off = 1'b0;
          end
          begin
            burst_mode = 1'b1;
            for (int k = 0; k < 6; k++) send_message($urandom_range(0, 5), 1'b0);
            burst_mode = 1'b0;
            msg_valid <= 1'b0;
            @(posedge clk);
          end
        join
      end
      wait_drained();
    end

    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("multiply_fold_byte_hash64 test passed");
    end else begin
      $display("multiply_fold_byte_hash64 test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
